// ----- rtl/qcfs_pkg.sv -----
package qcfs_pkg;

   localparam int HOLD_DEPTH_DEFAULT  = 32;
   localparam int MAX_NESTING_DEFAULT = 255;

   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   function automatic logic is_white(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

// ----- rtl/qcfs_if.sv -----
interface qcfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       string_last;

   modport source (output valid, char_in, string_last, input ready);
   modport sink (input valid, char_in, string_last, output ready);
endinterface

interface qcfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       byte_valid;
   logic       field_end;
   logic       whitespace_lost;
   logic       string_end;
   logic       run_last;

   modport source (output valid, byte_out, byte_valid, field_end, whitespace_lost,
                   string_end, run_last, input ready);
   modport sink (input valid, byte_out, byte_valid, field_end, whitespace_lost,
                 string_end, run_last, output ready);
endinterface

// ----- rtl/quote_aware_comma_field_splitter_top.sv -----
// Splits a byte stream into comma separated fields, honoring single quotes,
// double quotes and parentheses, and trims whitespace around each field.
// The req channel takes one byte per item with a flag on the last byte of a
// string. The rsp channel gives zero or more items per byte: field bytes,
// field ends and an end of string marker, with run_last on the final item of
// each input byte. Every result passes through one output register: the
// first result of a byte is offered right after the edge that accepts it, or
// one cycle later when held whitespace has to be read back first.
// A byte that yields at most one result takes one cycle. A content byte that
// follows N held whitespace bytes takes N + 2 cycles: one to accept it and
// start the read of the hold memory, N to send the held bytes and one for the
// byte itself. A content byte that ends the string adds one cycle for its
// field end.
// A new byte is taken only when the previous byte has put out all results
// and the output register is free or being emptied in the same cycle.
// When the receiver stalls, the pending result holds and input stops.
// Reset is synchronous and clears the quote, nesting and field state; the
// hold memory needs no clearing since only written entries are read.
module quote_aware_comma_field_splitter_top #(
   parameter int HOLD_DEPTH  = qcfs_pkg::HOLD_DEPTH_DEFAULT,
   parameter int MAX_NESTING = qcfs_pkg::MAX_NESTING_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   qcfs_req_if.sink   req_chan,
   qcfs_rsp_if.source rsp_chan
);
   import qcfs_pkg::*;

   localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   qcfs_ctrl #(
      .HOLD_DEPTH  (HOLD_DEPTH),
      .MAX_NESTING (MAX_NESTING)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   qcfs_hold_buf #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_hold_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/qcfs_hold_buf.sv -----
module qcfs_hold_buf #(
   parameter int HOLD_DEPTH = qcfs_pkg::HOLD_DEPTH_DEFAULT,
   localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);
   import qcfs_pkg::*;

   logic [7:0] mem [HOLD_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/qcfs_ctrl.sv -----
module qcfs_ctrl #(
   parameter int HOLD_DEPTH  = qcfs_pkg::HOLD_DEPTH_DEFAULT,
   parameter int MAX_NESTING = qcfs_pkg::MAX_NESTING_DEFAULT,
   localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   qcfs_req_if.sink         req,
   qcfs_rsp_if.source       rsp,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic [7:0]       wr_data,
   output logic [IDX_W-1:0] rd_addr,
   input  logic [7:0]       rd_data
);
   import qcfs_pkg::*;

   localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
   localparam int DEP_W = $clog2(MAX_NESTING + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_BYTE,
      ST_FEND
   } state_type;

   state_type        state_ff, state_in;
   logic             squote_ff, squote_in;
   logic             dquote_ff, dquote_in;
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic             content_ff, content_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_out_ff, byte_out_in;
   logic             byte_valid_ff, byte_valid_in;
   logic             field_end_ff, field_end_in;
   logic             lost_ff, lost_in;
   logic             string_end_ff, string_end_in;
   logic             run_last_ff, run_last_in;

   logic             can_emit;
   logic             accept;
   logic             split;
   logic             ovf_next;
   logic             emit;
   logic [7:0]       e_byte;
   logic             e_valid, e_fend, e_lost, e_send, e_rlast;

   assign can_emit  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && can_emit;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in   = state_ff;
      squote_in  = squote_ff;
      dquote_in  = dquote_ff;
      depth_in   = depth_ff;
      content_in = content_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      split      = 1'b0;
      ovf_next   = ovf_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = req.char_in;
      emit       = 1'b0;
      e_byte     = 8'd0;
      e_valid    = 1'b0;
      e_fend     = 1'b0;
      e_lost     = ovf_ff;
      e_send     = 1'b0;
      e_rlast    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req.char_in == CHAR_SQUOTE) && !dquote_ff) begin
                  squote_in = !squote_ff;
               end else if ((req.char_in == CHAR_DQUOTE) && !squote_ff) begin
                  dquote_in = !dquote_ff;
               end else if (!squote_ff && !dquote_ff) begin
                  if (req.char_in == CHAR_LPAREN) begin
                     if (depth_ff < DEP_W'(MAX_NESTING)) begin
                        depth_in = depth_ff + DEP_W'(1);
                     end
                  end else if (req.char_in == CHAR_RPAREN) begin
                     if (depth_ff != '0) begin
                        depth_in = depth_ff - DEP_W'(1);
                     end
                  end else if ((req.char_in == CHAR_COMMA) && (depth_ff == '0)) begin
                     split = 1'b1;
                  end
               end

               if (split) begin
                  emit       = 1'b1;
                  e_fend     = 1'b1;
                  e_send     = req.string_last;
                  e_rlast    = 1'b1;
                  content_in = 1'b0;
                  count_in   = '0;
                  ovf_in     = 1'b0;
               end else if (is_white(req.char_in)) begin
                  if (content_ff) begin
                     if (count_ff < CNT_W'(HOLD_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        ovf_next = 1'b1;
                     end
                  end
                  if (req.string_last) begin
                     emit       = 1'b1;
                     e_fend     = content_ff;
                     e_lost     = ovf_next;
                     e_send     = 1'b1;
                     e_rlast    = 1'b1;
                     content_in = 1'b0;
                     count_in   = '0;
                     ovf_in     = 1'b0;
                  end else begin
                     ovf_in = ovf_next;
                  end
               end else begin
                  char_in = req.char_in;
                  last_in = req.string_last;
                  if (count_ff != '0) begin
                     idx_in   = '0;
                     state_in = ST_FLUSH;
                  end else begin
                     emit       = 1'b1;
                     e_byte     = req.char_in;
                     e_valid    = 1'b1;
                     e_rlast    = !req.string_last;
                     content_in = 1'b1;
                     if (req.string_last) begin
                        state_in = ST_FEND;
                     end
                  end
               end

               if (req.string_last) begin
                  squote_in = 1'b0;
                  dquote_in = 1'b0;
                  depth_in  = '0;
               end
            end
         end
         ST_FLUSH: begin
            if (can_emit) begin
               emit    = 1'b1;
               e_byte  = rd_data;
               e_valid = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
               if (idx_ff == count_ff - CNT_W'(1)) begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (can_emit) begin
               emit       = 1'b1;
               e_byte     = char_ff;
               e_valid    = 1'b1;
               e_rlast    = !last_ff;
               count_in   = '0;
               content_in = 1'b1;
               state_in   = last_ff ? ST_FEND : ST_IDLE;
            end
         end
         ST_FEND: begin
            if (can_emit) begin
               emit       = 1'b1;
               e_fend     = 1'b1;
               e_send     = 1'b1;
               e_rlast    = 1'b1;
               content_in = 1'b0;
               count_in   = '0;
               ovf_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_addr = idx_in[IDX_W-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      byte_out_in   = byte_out_ff;
      byte_valid_in = byte_valid_ff;
      field_end_in  = field_end_ff;
      lost_in       = lost_ff;
      string_end_in = string_end_ff;
      run_last_in   = run_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         byte_out_in   = e_byte;
         byte_valid_in = e_valid;
         field_end_in  = e_fend;
         lost_in       = e_lost;
         string_end_in = e_send;
         run_last_in   = e_rlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         squote_ff    <= 1'b0;
         dquote_ff    <= 1'b0;
         depth_ff     <= '0;
         content_ff   <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         squote_ff    <= squote_in;
         dquote_ff    <= dquote_in;
         depth_ff     <= depth_in;
         content_ff   <= content_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      last_ff       <= last_in;
      byte_out_ff   <= byte_out_in;
      byte_valid_ff <= byte_valid_in;
      field_end_ff  <= field_end_in;
      lost_ff       <= lost_in;
      string_end_ff <= string_end_in;
      run_last_ff   <= run_last_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.byte_out        = byte_out_ff;
   assign rsp.byte_valid      = byte_valid_ff;
   assign rsp.field_end       = field_end_ff;
   assign rsp.whitespace_lost = lost_ff;
   assign rsp.string_end      = string_end_ff;
   assign rsp.run_last        = run_last_ff;

endmodule
